>>> hdl/cfp_pkg.sv
// Shared types and constants for the checksummed frame parser.
`default_nettype none

package cfp_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 6;
	localparam int PAIR_W = 4;

	localparam logic [BYTE_W-1:0] HEADER_RESET     = 8'hAA;
	localparam logic [POS_W-1:0]  MAX_LEN_RESET    = 6'd30;
	localparam logic [BYTE_W-1:0] MIN_FRAME_LENGTH = 8'd4;
	localparam logic [PAIR_W-1:0] MAX_PAIRS        = 4'd13;

	// Byte positions inside a frame
	localparam logic [POS_W-1:0] POS_HEADER  = 6'd0;
	localparam logic [POS_W-1:0] POS_LENGTH  = 6'd1;
	localparam logic [POS_W-1:0] POS_PAYLOAD = 6'd2;

	// Configuration register indexes
	localparam logic CFG_HEADER_BYTE      = 1'b0;
	localparam logic CFG_MAX_FRAME_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_RD_COLOR,
		ST_RD_STATE,
		ST_LOAD
	} ctrl_state_t;

	typedef struct packed {
		logic              we;
		logic [POS_W-1:0]  waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [POS_W-1:0]  raddr;
	} ram_req_t;

endpackage

`default_nettype wire

>>> hdl/checksummed_frame_parser.sv
// Top level of the checksummed frame parser: framing, checksum and pair readout.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | in        | in_valid/in_stall  | in_byte
//  out     | out       | out_valid/out_stall| led_color, led_state, last_pair
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// After a frame whose checksum matches, the input stalls while the P pairs are read
// out of the frame buffer: each pair takes two reads on the single buffer read port
// and then an output load, which waits while the output stalls. Reset puts the
// parser in the hunting state and the registers at their defaults; the buffer is
// not cleared. A finished pair waits in the output register while the next byte is
// taken.
`default_nettype none

module checksummed_frame_parser #(
	parameter int BUFFER_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      led_color,
	output logic [7:0]      led_state,
	output logic            last_pair,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int PW = cfp_pkg::POS_W;
	localparam int BW = cfp_pkg::BYTE_W;
	localparam int KW = cfp_pkg::PAIR_W;

	cfp_pkg::ctrl_state_t state_q, state_d;

	logic [BW-1:0] header_q;
	logic [PW-1:0] max_len_q;

	logic [PW-1:0] pos_q, pos_d;
	logic [PW-1:0] len_q, len_d;
	logic [BW-1:0] sum_q, sum_d;

	logic [PW-1:0] ptr_q;
	logic [KW-1:0] pairs_left_q;

	logic          out_valid_q;
	logic [BW-1:0] color_q;
	logic [BW-1:0] state_byte_q;
	logic          last_q;
	logic [BW-1:0] color_hold_q;

	cfp_pkg::ram_req_t ram_req;
	logic [BW-1:0]     rd_data;

	logic          in_acc;
	logic          wr_en;
	logic          emit_go;
	logic          load_out;
	logic          slot_free;
	logic          len_bad;
	logic [PW-1:0] pos_inc;
	logic [PW-1:0] pairs_raw;
	logic [KW-1:0] pairs;

	cfp_frame_ram #(
		.DEPTH(BUFFER_DEPTH)
	) u_ram (
		.clk    (clk),
		.req    (ram_req),
		.rd_data(rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= cfp_pkg::HEADER_RESET;
			max_len_q <= cfp_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cfp_pkg::CFG_HEADER_BYTE:      header_q  <= cfg_data;
				cfp_pkg::CFG_MAX_FRAME_LENGTH: max_len_q <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign pos_inc   = pos_q + PW'(1);
	assign pairs_raw = (len_q - PW'(3)) >> 1;
	assign pairs     = (pairs_raw > PW'(cfp_pkg::MAX_PAIRS)) ? cfp_pkg::MAX_PAIRS
	                                                         : pairs_raw[KW-1:0];
	assign len_bad   = (in_byte < cfp_pkg::MIN_FRAME_LENGTH)
	                || ({1'b0, in_byte} > {3'b000, max_len_q})
	                || ({1'b0, in_byte} > 9'(BUFFER_DEPTH));

	// per-byte framing step
	always_comb begin
		pos_d   = pos_q;
		len_d   = len_q;
		sum_d   = sum_q;
		wr_en   = 1'b0;
		emit_go = 1'b0;
		if (in_acc) begin
			if (pos_q == cfp_pkg::POS_HEADER) begin
				if (in_byte == header_q) begin
					wr_en = 1'b1;
					sum_d = in_byte;
					pos_d = cfp_pkg::POS_LENGTH;
				end
			end else if (pos_q == cfp_pkg::POS_LENGTH) begin
				if (len_bad) begin
					pos_d = cfp_pkg::POS_HEADER;
					len_d = '0;
					sum_d = '0;
				end else begin
					wr_en = 1'b1;
					len_d = in_byte[PW-1:0];
					sum_d = sum_q + in_byte;
					pos_d = cfp_pkg::POS_PAYLOAD;
				end
			end else if (pos_q >= len_q) begin
				pos_d = cfp_pkg::POS_HEADER;
				len_d = '0;
				sum_d = '0;
			end else begin
				wr_en = 1'b1;
				if (pos_inc < len_q) begin
					sum_d = sum_q + in_byte;
					pos_d = pos_inc;
				end else begin
					// checksum byte: compare and go back to hunting
					emit_go = (in_byte == sum_q) && (pairs != '0);
					pos_d   = cfp_pkg::POS_HEADER;
					len_d   = '0;
					sum_d   = '0;
				end
			end
		end
	end

	// control sequencer and buffer access
	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		load_out      = 1'b0;
		ram_req.we    = wr_en;
		ram_req.waddr = pos_q;
		ram_req.wdata = in_byte;
		ram_req.re    = 1'b0;
		ram_req.raddr = ptr_q;
		case (state_q)
			cfp_pkg::ST_RUN: begin
				in_stall = 1'b0;
				if (emit_go) begin
					state_d = cfp_pkg::ST_RD_COLOR;
				end
			end
			cfp_pkg::ST_RD_COLOR: begin
				ram_req.re = 1'b1;
				state_d    = cfp_pkg::ST_RD_STATE;
			end
			cfp_pkg::ST_RD_STATE: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = ptr_q + PW'(1);
				state_d       = cfp_pkg::ST_LOAD;
			end
			cfp_pkg::ST_LOAD: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = (pairs_left_q == KW'(1)) ? cfp_pkg::ST_RUN
					                                    : cfp_pkg::ST_RD_COLOR;
				end
			end
			default: state_d = cfp_pkg::ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cfp_pkg::ST_RUN;
			pos_q        <= cfp_pkg::POS_HEADER;
			len_q        <= '0;
			sum_q        <= '0;
			ptr_q        <= cfp_pkg::POS_PAYLOAD;
			pairs_left_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
			if (emit_go) begin
				ptr_q        <= cfp_pkg::POS_PAYLOAD;
				pairs_left_q <= pairs;
			end else if (load_out) begin
				ptr_q        <= ptr_q + PW'(2);
				pairs_left_q <= pairs_left_q - KW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == cfp_pkg::ST_RD_STATE) begin
			color_hold_q <= rd_data;
		end
		if (load_out) begin
			color_q      <= color_hold_q;
			state_byte_q <= rd_data;
			last_q       <= (pairs_left_q == KW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign led_color = color_q;
	assign led_state = state_byte_q;
	assign last_pair = last_q;

	a_pairs_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != cfp_pkg::ST_RUN) |-> (pairs_left_q != '0))
		else $error("pair readout running with no pairs left");

	a_ptr_in_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != cfp_pkg::ST_RUN) |-> (32'(ptr_q) + 32'd1 < 32'(BUFFER_DEPTH)))
		else $error("pair read beyond frame buffer");

	a_last_ends_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && pairs_left_q == KW'(1)) |=> (state_q == cfp_pkg::ST_RUN && last_pair))
		else $error("last pair did not end readout");

	a_pos_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q >= cfp_pkg::POS_PAYLOAD) |-> (pos_q < len_q))
		else $error("byte position past frame length");

endmodule

`default_nettype wire

>>> hdl/cfp_frame_ram.sv
// Frame byte buffer: one write port, one registered read port.
`default_nettype none

module cfp_frame_ram #(
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire cfp_pkg::ram_req_t        req,
	output logic [cfp_pkg::BYTE_W-1:0]    rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [cfp_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [cfp_pkg::BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[AW'(req.waddr)] <= req.wdata;
		end
	end

	// hold read data while no read is issued
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data_q <= mem[AW'(req.raddr)];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> verif/tb_checksummed_frame_parser.sv
// Self-checking testbench for the checksummed frame parser: framing, checksum and pair readout.
module tb_checksummed_frame_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUFFER_DEPTH  = 32;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 12;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [7:0]  value;
		int unsigned gap;
	} rx_item_t;

	typedef struct {
		logic [7:0] color;
		logic [7:0] state;
		logic       last;
	} led_pair_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] led_color;
	logic [7:0] led_state;
	logic       last_pair;
	logic       cfg_we    = 1'b0;
	logic       cfg_index = 1'b0;
	logic [7:0] cfg_data  = 8'h00;

	checksummed_frame_parser #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.led_color(led_color),
		.led_state(led_state),
		.last_pair(last_pair),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Parser model state and register copies
	logic [7:0] hdr_cfg    = cfp_pkg::HEADER_RESET;
	logic [5:0] maxlen_cfg = cfp_pkg::MAX_LEN_RESET;
	int         rx_pos     = 0;
	int         frame_len  = 0;
	logic [7:0] rx_sum     = 8'h00;
	logic [7:0] frame_bytes[BUFFER_DEPTH];

	led_pair_t  expected_pairs[$];
	rx_item_t   rx_pending[$];

	int  bytes_queued   = 0;
	int  bytes_accepted = 0;
	int  pairs_checked  = 0;
	int  good_frames    = 0;
	int  mismatches     = 0;
	int  cycle_count    = 0;
	int  stall_left     = 0;
	bit  gap_mode       = 1'b0;
	bit  stall_mode     = 1'b0;
	bit  in_taken       = 1'b0;

	function automatic void parse_rx_byte(input logic [7:0] b);
		int n_pairs;
		if (rx_pos == 0) begin
			if (b == hdr_cfg) begin
				frame_bytes[0] = b;
				rx_sum = b;
				rx_pos = 1;
			end
		end else if (rx_pos == 1) begin
			if (b < cfp_pkg::MIN_FRAME_LENGTH || b > maxlen_cfg || b > BUFFER_DEPTH) begin
				rx_pos = 0;
				frame_len = 0;
				rx_sum = 8'h00;
			end else begin
				frame_len = b;
				frame_bytes[1] = b;
				rx_sum = rx_sum + b;
				rx_pos = 2;
			end
		end else begin
			frame_bytes[rx_pos] = b;
			rx_pos++;
			if (rx_pos < frame_len) begin
				rx_sum = rx_sum + b;
			end else begin
				// b is the checksum
				if (b == rx_sum) begin
					good_frames++;
					n_pairs = (frame_len - 3) / 2;
					if (n_pairs > cfp_pkg::MAX_PAIRS)
						n_pairs = cfp_pkg::MAX_PAIRS;
					for (int k = 0; k < n_pairs; k++)
						expected_pairs.push_back('{frame_bytes[2 + 2 * k],
							frame_bytes[3 + 2 * k], k + 1 == n_pairs});
				end
				rx_pos = 0;
				frame_len = 0;
				rx_sum = 8'h00;
			end
		end
	endfunction

	// Mostly short idles, now and then a long one
	function automatic int idle_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic byte_q_t random_body(input int n);
		byte_q_t body;
		for (int i = 0; i < n; i++)
			body.push_back(8'($urandom));
		return body;
	endfunction

	task automatic queue_byte(input logic [7:0] value);
		int unsigned gap;
		gap = gap_mode ? idle_length() : 0;
		rx_pending.push_back('{value, gap});
		bytes_queued++;
	endtask

	// Length byte counts header, length, payload and checksum
	task automatic queue_frame(input logic [7:0] hdr, input byte_q_t body, input bit bad_sum);
		logic [7:0] sum;
		logic [7:0] len;
		len = 8'(body.size() + 3);
		sum = hdr + len;
		queue_byte(hdr);
		queue_byte(len);
		foreach (body[i]) begin
			queue_byte(body[i]);
			sum = sum + body[i];
		end
		queue_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
	endtask

	task automatic random_traffic(input int min_bytes, input int min_pairs);
		int start_bytes;
		int pair_est;
		int pick;
		int lmax;
		int len;
		start_bytes = bytes_queued;
		pair_est = 0;
		lmax = (maxlen_cfg > BUFFER_DEPTH) ? BUFFER_DEPTH : maxlen_cfg;
		while (bytes_queued - start_bytes < min_bytes || pair_est < min_pairs) begin
			pick = $urandom_range(0, 99);
			if (lmax < 4)
				len = 4;
			else if ($urandom_range(0, 4) == 0)
				len = $urandom_range(4, lmax);
			else
				len = $urandom_range(4, (lmax < 12) ? lmax : 12);
			if (pick < 70 && lmax >= 4) begin
				queue_frame(hdr_cfg, random_body(len - 3), 1'b0);
				pair_est += ((len - 3) / 2 > cfp_pkg::MAX_PAIRS) ? cfp_pkg::MAX_PAIRS
					: (len - 3) / 2;
			end else if (pick < 80) begin
				queue_frame(hdr_cfg, random_body(len - 3), 1'b1);
			end else if (pick < 88) begin
				queue_byte(hdr_cfg);
				if ($urandom_range(0, 1))
					queue_byte(8'($urandom_range(0, 3)));
				else
					queue_byte(8'($urandom_range(lmax + 1, 255)));
			end else if (pick < 94) begin
				// cut the frame short; the following bytes fill it up
				queue_byte(hdr_cfg);
				queue_byte(8'(len));
				repeat ($urandom_range(0, len - 4))
					queue_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 4))
					queue_byte(8'($urandom));
			end
		end
	endtask

	task automatic wait_drained();
		while (bytes_accepted != bytes_queued || expected_pairs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == cfp_pkg::CFG_HEADER_BYTE)
			hdr_cfg = value;
		else
			maxlen_cfg = value[5:0];
	endtask

	// Input driver: hold a transaction until taken, then advance
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte  <= 8'h00;
		end else if (!in_valid || in_taken) begin
			if (rx_pending.size() == 0) begin
				in_valid <= 1'b0;
			end else if (rx_pending[0].gap != 0) begin
				in_valid <= 1'b0;
				rx_pending[0].gap = rx_pending[0].gap - 1;
			end else begin
				in_valid <= 1'b1;
				in_byte  <= rx_pending[0].value;
				rx_pending.delete(0);
			end
		end
	end

	// Output backpressure
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (stall_mode)
				stall_left = idle_length();
		end
	end

	// Monitor: predict on accepted bytes, check accepted pairs
	always @(posedge clk) begin
		led_pair_t exp_pair;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				parse_rx_byte(in_byte);
				bytes_accepted++;
			end
			if (out_valid && !out_stall) begin
				if (expected_pairs.size() == 0) begin
					$error("unexpected pair: led_color 0x%02h led_state 0x%02h last_pair %0b",
						led_color, led_state, last_pair);
					mismatches++;
				end else begin
					exp_pair = expected_pairs.pop_front();
					pairs_checked++;
					if (led_color !== exp_pair.color) begin
						$error("led_color: expected 0x%02h, got 0x%02h", exp_pair.color, led_color);
						mismatches++;
					end
					if (led_state !== exp_pair.state) begin
						$error("led_state: expected 0x%02h, got 0x%02h", exp_pair.state, led_state);
						mismatches++;
					end
					if (last_pair !== exp_pair.last) begin
						$error("last_pair: expected %0b, got %0b", exp_pair.last, last_pair);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		byte_q_t body;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default registers: bad lengths, extremes, odd payload, header as data
		queue_byte(8'h55);
		queue_byte(cfp_pkg::HEADER_RESET);
		queue_byte(8'd3);
		queue_byte(cfp_pkg::HEADER_RESET);
		queue_byte(8'd0);
		queue_byte(cfp_pkg::HEADER_RESET);
		queue_byte(8'd31);
		body = {8'h00, 8'hFF};
		queue_frame(hdr_cfg, body, 1'b0);
		body = {8'hFF, 8'h00, cfp_pkg::HEADER_RESET};
		queue_frame(hdr_cfg, body, 1'b0);
		body = {8'h12};
		queue_frame(hdr_cfg, body, 1'b0);
		body = {cfp_pkg::HEADER_RESET, cfp_pkg::HEADER_RESET};
		queue_frame(hdr_cfg, body, 1'b1);
		wait_drained();

		gap_mode = 1'b1;
		stall_mode = 1'b1;
		random_traffic(20, 6);
		wait_drained();

		// Zero header, full buffer: pair count capped
		write_reg(cfp_pkg::CFG_HEADER_BYTE, 8'h00);
		write_reg(cfp_pkg::CFG_MAX_FRAME_LENGTH, 8'd32);
		stall_mode = 1'b0;
		queue_frame(hdr_cfg, random_body(29), 1'b0);
		wait_drained();

		// Largest maximum: lengths past the buffer are dropped
		write_reg(cfp_pkg::CFG_HEADER_BYTE, 8'hFF);
		write_reg(cfp_pkg::CFG_MAX_FRAME_LENGTH, 8'd63);
		gap_mode = 1'b0;
		stall_mode = 1'b1;
		queue_byte(hdr_cfg);
		queue_byte(8'd33);
		queue_byte(hdr_cfg);
		queue_byte(8'd63);
		random_traffic(8, 2);
		wait_drained();

		// Maximum below the minimum length rejects everything
		write_reg(cfp_pkg::CFG_MAX_FRAME_LENGTH, 8'd0);
		gap_mode = 1'b1;
		queue_byte(hdr_cfg);
		queue_byte(8'd4);
		random_traffic(4, 0);
		wait_drained();

		write_reg(cfp_pkg::CFG_MAX_FRAME_LENGTH, 8'd4);
		queue_frame(hdr_cfg, random_body(1), 1'b0);
		queue_frame(hdr_cfg, random_body(1), 1'b1);
		queue_frame(hdr_cfg, random_body(2), 1'b0);
		wait_drained();

		write_reg(cfp_pkg::CFG_HEADER_BYTE, 8'($urandom));
		write_reg(cfp_pkg::CFG_MAX_FRAME_LENGTH, 8'($urandom_range(5, 32)));
		random_traffic(10, 3);
		wait_drained();
		repeat (50) @(negedge clk);

		$display("Covered %0d bytes, %0d frames with a good checksum, %0d pairs checked,",
			bytes_accepted, good_frames, pairs_checked);
		$display("headers 0x00/0xAA/0xFF/random and length limits 0, 4, 30, 32, 63 and random");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
hdl/cfp_pkg.sv
hdl/cfp_frame_ram.sv
hdl/checksummed_frame_parser.sv
verif/tb_checksummed_frame_parser.sv
